[hw/rtl/rfe_pkg.sv]
// Shared constants, tables and control types of the Rastrigin fitness evaluator.
`timescale 1ns / 1ps
`default_nettype none
package rfe_pkg;

	// Fixed-point format of the decision variables
	localparam int X_W       = 16;
	localparam int FRAC_BITS = 12;

	// Running sum and result width
	localparam int                 SUM_W   = 28;
	localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};

	// CORDIC rotator
	localparam int CORDIC_STEPS = 14;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CX_W         = 20;
	localparam int Z_W          = 18;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 20'sd39797;

	// Arctangent of 2^-i in units of 2^-16 turn
	localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
		18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
	};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic              step;
		logic [STEP_W-1:0] step_idx;
		logic              term;
		logic              acc;
		logic              emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/rfe_datapath.sv]
// Datapath: square, CORDIC cosine, term build, saturating sum and output word register.
`timescale 1ns / 1ps
`default_nettype none
module rfe_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rfe_pkg::cmd_t                     cmd,
	output rfe_pkg::sts_t                          sts,
	input  wire logic signed [rfe_pkg::X_W-1:0]    x_value,
	input  wire logic                              last_var,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [rfe_pkg::SUM_W-1:0]              objective_value,
	output logic                                   saturated
);

	localparam int F      = rfe_pkg::FRAC_BITS;
	localparam int XW     = rfe_pkg::X_W;
	localparam int CXW    = rfe_pkg::CX_W;
	localparam int ZW     = rfe_pkg::Z_W;
	localparam int SW     = rfe_pkg::SUM_W;
	localparam int PROD_W = 2 * XW;
	localparam int SQ_W   = PROD_W - F;
	localparam int D_W    = 18;
	localparam int D10_W  = D_W + 4;
	localparam int WIDE_W = D10_W + F;
	localparam int W_W    = WIDE_W - 16;
	localparam int TERM_W = ((SQ_W > W_W) ? SQ_W : W_W) + 1;

	logic signed [XW-1:0]     x_q;
	logic                     last_q;
	logic                     flip_q;
	logic signed [CXW-1:0]    cx_q;
	logic signed [CXW-1:0]    cy_q;
	logic signed [ZW-1:0]     z_q;
	logic [SQ_W-1:0]          sq_q;
	logic [TERM_W-1:0]        term_q;
	logic [SW-1:0]            sum_q;
	logic                     ov_q;
	logic                     out_valid_q;
	logic [SW-1:0]            obj_q;
	logic                     sat_q;

	// Phase and fold of the incoming word
	logic [F+15:0]            ph_wide;
	logic signed [ZW-1:0]     a_ext;
	logic signed [ZW-1:0]     z_init;
	logic                     flip_init;

	always_comb begin
		ph_wide = {x_value[F-1:0], 16'b0} >> F;
		a_ext   = ZW'($signed(ph_wide[15:0]));
		if (a_ext > 18'sd16384) begin
			z_init    = a_ext - 18'sd32768;
			flip_init = 1'b1;
		end else if (a_ext < -18'sd16384) begin
			z_init    = a_ext + 18'sd32768;
			flip_init = 1'b1;
		end else begin
			z_init    = a_ext;
			flip_init = 1'b0;
		end
	end

	// One CORDIC rotation step
	logic signed [CXW-1:0] dx;
	logic signed [CXW-1:0] dy;
	logic signed [ZW-1:0]  at;

	assign dx = cy_q >>> cmd.step_idx;
	assign dy = cx_q >>> cmd.step_idx;
	assign at = rfe_pkg::ATAN_TURNS[cmd.step_idx];

	// Rounded square
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        sq_round;

	assign prod     = x_q * x_q;
	assign sq_round = $unsigned(prod) + PROD_W'(1 << (F - 1));

	// Cosine term from the rotator output
	logic signed [CXW-1:0] c_neg;
	logic signed [CXW-1:0] c_clamp;
	logic signed [CXW-1:0] d_full;
	logic [D_W-1:0]        d;
	logic [D10_W-1:0]      d10;
	logic [WIDE_W-1:0]     wide;

	always_comb begin
		c_neg = flip_q ? -cx_q : cx_q;
		if (c_neg > 20'sd65536)
			c_clamp = 20'sd65536;
		else if (c_neg < -20'sd65536)
			c_clamp = -20'sd65536;
		else
			c_clamp = c_neg;
		d_full = 20'sd65536 - c_clamp;
		d      = d_full[D_W-1:0];
		d10    = ({4'b0, d} << 3) + ({4'b0, d} << 1);
		wide   = {d10, {F{1'b0}}} + WIDE_W'(32768);
	end

	// Saturating accumulate
	logic [SW:0] sum_w;
	logic        sat_now;
	logic [SW-1:0] sum_nxt;
	logic          ov_nxt;

	always_comb begin
		sum_w   = {1'b0, sum_q} + (SW+1)'(term_q);
		sat_now = sum_w[SW];
		sum_nxt = sat_now ? rfe_pkg::SUM_MAX : sum_w[SW-1:0];
		ov_nxt  = ov_q | sat_now;
	end

	// Load the word, run the rotator, build the term and capture the output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_value;
			last_q <= last_var;
			flip_q <= flip_init;
			cx_q   <= rfe_pkg::CORDIC_GAIN;
			cy_q   <= '0;
			z_q    <= z_init;
		end else if (cmd.step) begin
			sq_q <= sq_round[PROD_W-1:F];
			if (z_q >= 0) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + at;
			end
		end
		if (cmd.term)
			term_q <= TERM_W'(sq_q) + TERM_W'(wide[WIDE_W-1:16]);
		if (cmd.emit) begin
			obj_q <= sum_nxt;
			sat_q <= ov_nxt;
		end
	end

	// Hold the sum across the solution and clear it at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ov_q  <= 1'b0;
		end else if (cmd.acc) begin
			if (cmd.emit) begin
				sum_q <= '0;
				ov_q  <= 1'b0;
			end else begin
				sum_q <= sum_nxt;
				ov_q  <= ov_nxt;
			end
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid       = out_valid_q;
	assign objective_value = obj_q;
	assign saturated       = sat_q;
	assign sts.last        = last_q;
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule
`default_nettype wire

[hw/rtl/rfe_ctrl.sv]
// Controller: sequences load, CORDIC steps, term build and accumulate for each word.
`timescale 1ns / 1ps
`default_nettype none
module rfe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rfe_pkg::sts_t sts,
	output rfe_pkg::cmd_t      cmd
);

	localparam int SW_ = rfe_pkg::STEP_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_TERM = 4'b0100,
		ST_ACC  = 4'b1000
	} state_t;

	state_t        state_q;
	state_t        state_nxt;
	logic [SW_-1:0] cnt_q;
	logic           last_step;

	assign last_step = (cnt_q == SW_'(rfe_pkg::CORDIC_STEPS - 1));
	assign in_ready  = (state_q == ST_IDLE);

	// Decode state into commands and next state
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.step_idx = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (last_step)
					state_nxt = ST_TERM;
			end
			ST_TERM: begin
				cmd.term  = 1'b1;
				state_nxt = ST_ACC;
			end
			ST_ACC: begin
				if (!sts.last || sts.out_free) begin
					cmd.acc   = 1'b1;
					cmd.emit  = sts.last;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.step)
				cnt_q <= cnt_q + SW_'(1);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rastrigin_fitness_eval_top.sv]
// Rastrigin fitness evaluator: top level joining controller and datapath.
//
// Usage: the input channel (in_valid/in_ready) takes one decision variable
// per word, signed with FRAC_BITS fraction bits, with last_var marking the
// final variable of a candidate. Each word adds x*x + 10 - 10*cos(2*pi*x) to
// a running sum. On the last word, the output channel (out_valid/out_ready)
// carries the saturated objective and a flag that is set if the sum was
// clamped at any point during that candidate; the sum then clears.
// Sequence: each word is taken in the load cycle, then passes through 14
// iterations of the shared CORDIC rotator, the term build and the
// accumulate, after which in_ready rises again; no new word is accepted
// before then. Most of this sequence is spent in the rotator loop.
// out_valid rises on the cycle after the last word's accumulate. The output
// register lets the next word enter while a result waits; if the receiver
// still stalls when the next last word is ready to accumulate, the block
// holds there until the register frees.
// Reset clears the running sum, the clamp flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module rastrigin_fitness_eval_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [rfe_pkg::X_W-1:0] x_value,
	input  wire logic                           last_var,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [rfe_pkg::SUM_W-1:0]           objective_value,
	output logic                                saturated
);

	rfe_pkg::cmd_t cmd;
	rfe_pkg::sts_t sts;

	// Sequence each word
	rfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Compute and accumulate
	rfe_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.x_value         (x_value),
		.last_var        (last_var),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.objective_value (objective_value),
		.saturated       (saturated)
	);

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the Rastrigin fitness evaluator, with stimulus, model and checks.
`timescale 1ns / 1ps
module tb_top;

	localparam int               X_W       = rfe_pkg::X_W;
	localparam int               FRAC_BITS = rfe_pkg::FRAC_BITS;
	localparam int               SUM_W     = rfe_pkg::SUM_W;
	localparam logic [SUM_W-1:0] SUM_MAX   = rfe_pkg::SUM_MAX;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 20;
	localparam int ROT_STEPS    = 14;
	localparam int ATAN_Q16 [ROT_STEPS] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
	};

	typedef struct {
		logic [SUM_W-1:0] obj;
		logic             sat;
	} objective_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic signed [X_W-1:0] x_value     = '0;
	logic                  last_var    = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [SUM_W-1:0]      objective_value;
	logic                  saturated;

	// predicted state of the evaluator and the objectives still owed
	objective_t       objective_q [$];
	logic [SUM_W-1:0] model_sum   = '0;
	logic             model_ovf   = 1'b0;

	int   err_count     = 0;
	int   quiet_cycles  = 0;
	int   rx_hold_left  = 0;
	int   rx_stall_left = 0;
	bit   tx_idle_en    = 1'b1;
	logic rx_idle_en    = 1'b1;
	logic rx_hold_req   = 1'b0;

	rastrigin_fitness_eval_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.x_value         (x_value),
		.last_var        (last_var),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.objective_value (objective_value),
		.saturated       (saturated)
	);

	always #5 clk = ~clk;

	// CORDIC cosine of a phase in 2^-16 turn, result in Q.16
	function automatic int cordic_cos(logic [15:0] phase);
		int  ang, cx, cy, z, dx, dy;
		bit  flip;
		ang  = int'($signed(phase));
		flip = 1'b0;
		cx   = 39797;
		cy   = 0;
		// fold the outer half-plane onto the inner one, negate at the end
		if (ang > 16384) begin
			ang -= 32768;
			flip = 1'b1;
		end else if (ang < -16384) begin
			ang += 32768;
			flip = 1'b1;
		end
		z = ang;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z  -= ATAN_Q16[i];
			end else begin
				cx += dx;
				cy -= dy;
				z  += ATAN_Q16[i];
			end
		end
		if (flip)
			cx = -cx;
		if (cx > 65536)
			cx = 65536;
		if (cx < -65536)
			cx = -65536;
		return cx;
	endfunction

	// per-variable contribution: rounded square plus 10 - 10*cos(2*pi*x)
	function automatic longint variable_term(logic signed [X_W-1:0] x);
		longint      sq, w;
		logic [15:0] phase;
		sq    = (longint'(x) * longint'(x) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		phase = 16'(((longint'(x) & ((longint'(1) << FRAC_BITS) - 1)) << 16) >> FRAC_BITS);
		w     = (((longint'(10) * (65536 - cordic_cos(phase))) << FRAC_BITS) + 32768) >>> 16;
		return sq + w;
	endfunction

	// random variable: mostly in range, some raw patterns, edges and phase boundaries
	function automatic logic signed [X_W-1:0] pick_x();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return X_W'(int'($urandom_range(0, 41944)) - 20972);
		else if (r < 8)
			return X_W'($urandom());
		else if (r == 8) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sd20972;
				default: return -16'sd20972;
			endcase
		end
		return X_W'(($urandom_range(0, 15) << 12) + $urandom_range(0, 3) * 1024
			+ $urandom_range(0, 2) - 1);
	endfunction

	// send one word, then fold it into the predicted sum once accepted
	task automatic send_word(input logic signed [X_W-1:0] x, input logic last);
		longint sum;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value  <= x;
		last_var <= last;
		do @(posedge clk); while (!in_ready);
		sum = longint'(model_sum) + variable_term(x);
		if (sum > longint'(SUM_MAX)) begin
			sum       = SUM_MAX;
			model_ovf = 1'b1;
		end
		model_sum = sum[SUM_W-1:0];
		if (last) begin
			objective_q.push_back('{model_sum, model_ovf});
			model_sum = '0;
			model_ovf = 1'b0;
		end
	endtask

	// single-variable solutions at the edges of the input range, at zero and one LSB either side
	task automatic test_range_edges();
		send_word(16'sd0, 1'b1);
		send_word(16'sd20972, 1'b1);
		send_word(-16'sd20972, 1'b1);
		send_word(16'sh7FFF, 1'b1);
		send_word(16'sh8000, 1'b1);
		send_word(16'sd1, 1'b1);
		send_word(-16'sd1, 1'b1);
	endtask

	// fractions on and just past the quarter-turn fold points, and the half turn
	task automatic test_cosine_folds();
		send_word(16'sh0400, 1'b0);
		send_word(16'sh0401, 1'b1);
		send_word(16'sh1C00, 1'b0);
		send_word(-16'sd1025, 1'b1);
		send_word(16'sh0800, 1'b0);
		send_word(-16'sd2049, 1'b1);
	endtask

	// one solution of several mixed variables
	task automatic test_multi_var();
		send_word(16'sd4096, 1'b0);
		send_word(-16'sd4096, 1'b0);
		send_word(16'sd12288, 1'b0);
		send_word(-16'sd8187, 1'b0);
		send_word(16'sh0A3D, 1'b0);
		send_word(16'sd20000, 1'b1);
	endtask

	// large variables until the sum clamps, a few more, then a clean solution
	task automatic test_sum_saturation();
		longint                acc;
		int                    extra, xi;
		logic signed [X_W-1:0] x;
		acc   = 0;
		extra = 0;
		while (extra < 8) begin
			xi = $urandom_range(30720, 32767);
			if ($urandom_range(0, 1))
				xi = -xi - 1;
			x    = X_W'(xi);
			acc += variable_term(x);
			if (acc > longint'(SUM_MAX))
				extra++;
			send_word(x, extra == 8);
		end
		send_word(16'sd4096, 1'b1);
	endtask

	// hold the receiver off while short solutions keep coming
	task automatic test_output_backpressure();
		in_valid    <= 1'b0;
		rx_hold_req <= 1'b1;
		@(posedge clk);
		rx_hold_req <= 1'b0;
		repeat (4) send_word(pick_x(), 1'b1);
		send_word(pick_x(), 1'b0);
		send_word(pick_x(), 1'b1);
	endtask

	// random solutions, mostly short, now and then long
	task automatic test_random_solutions(input int n_words);
		int left, len;
		left = n_words;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			if (len > left)
				len = left;
			for (int k = 0; k < len; k++)
				send_word(pick_x(), k == len - 1);
			left -= len;
		end
	endtask

	// closing stretch with no idling on either side
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		test_random_solutions(100);
	endtask

	// drive out_ready: long hold on request, random stall bursts otherwise
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_stall_left = $urandom_range(0, 15);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each accepted objective with the oldest prediction
	always @(posedge clk) begin : check_proc
		objective_t want;
		if (arst_n && out_valid && out_ready) begin
			if (objective_q.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("%0t ns: objective with none pending: expected none, actual %0d sat %0b",
						$time, objective_value, saturated);
				err_count++;
			end else begin
				want = objective_q.pop_front();
				if (objective_value !== want.obj) begin
					if (err_count < MAX_REPORTS)
						$display("%0t ns: objective_value mismatch: expected %0d, actual %0d",
							$time, want.obj, objective_value);
					err_count++;
				end
				if (saturated !== want.sat) begin
					if (err_count < MAX_REPORTS)
						$display("%0t ns: saturated mismatch: expected %0b, actual %0b",
							$time, want.sat, saturated);
					err_count++;
				end
			end
		end
	end

	// stop the run when no word moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("rastrigin_fitness_eval_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_edges();
		test_cosine_folds();
		test_multi_var();
		test_sum_saturation();
		test_output_backpressure();
		test_random_solutions(550);
		test_full_rate();
		// drain outstanding objectives, then let the pipeline settle
		in_valid <= 1'b0;
		while (objective_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && objective_q.size() == 0)
			$display("rastrigin_fitness_eval_top regression: pass");
		else
			$display("rastrigin_fitness_eval_top regression: fail");
		$finish;
	end

endmodule

[rastrigin_fitness_eval_top.f]
hw/rtl/rfe_pkg.sv
hw/rtl/rfe_datapath.sv
hw/rtl/rfe_ctrl.sv
hw/rtl/rastrigin_fitness_eval_top.sv
sim/tb_top.sv
